[rtl/assert_macros.svh]
// Assertion macros for the RTL of the page frame allocator.
// Simulation builds get concurrent assertions; synthesis builds get empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define AM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define AM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define AM_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define AM_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[rtl/bpfa_pkg.sv]
// Package of the bitmap page frame allocator: widths, codes and helper functions.
// Used by bpfa_fill_word and bitmap_page_frame_allocator; depends on nothing.
package bpfa_pkg;

    localparam int MAP_BYTES_DEF  = 4096;
    localparam int PAGE_SHIFT_DEF = 12;

    localparam int KB_W   = 23;
    localparam int ADDR_W = 32;
    localparam int OPC_W  = 2;
    localparam int ST_W   = 2;
    localparam int WORD_W = 32;
    localparam int BIT_W  = 5;
    localparam int CNT_W  = 24;

    localparam logic CFG_INSTALLED_KB = 1'b0;
    localparam logic CFG_KERNEL_LIMIT = 1'b1;

    typedef enum logic [OPC_W-1:0] {
        OP_ALLOC   = 2'd0,
        OP_RELEASE = 2'd1,
        OP_INIT    = 2'd2,
        OP_NONE    = 2'd3
    } t_opcode;

    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    function automatic logic [BIT_W-1:0] lowest_zero(input logic [WORD_W-1:0] w);
        logic [BIT_W-1:0] idx;
        idx = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (!w[i]) begin
                idx = BIT_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

[rtl/bitmap_page_frame_allocator.sv]
// Bitmap page frame allocator, first fit, map held in one synchronous RAM of 32-bit words.
// Allocate: scans one word at a time from the lowest word that may hold a free page.
// Release: reads, then rewrites the word with the bit cleared. Initialize: writes every word.
// After reset a clearing pass writes zero to all (MAP_BYTES + 3) / 4 words, one per cycle,
// during which no item is accepted; configuration writes are taken at any time.
// Depends on bpfa_pkg, bpfa_fill_word and assert_macros.svh.
`include "assert_macros.svh"

module bitmap_page_frame_allocator #(
    parameter int MAP_BYTES  = bpfa_pkg::MAP_BYTES_DEF,
    parameter int PAGE_SHIFT = bpfa_pkg::PAGE_SHIFT_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic                        i_cfg_index,
    input  logic [bpfa_pkg::ADDR_W-1:0] i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [bpfa_pkg::OPC_W-1:0]  i_opcode,
    input  logic [bpfa_pkg::ADDR_W-1:0] i_release_address,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [bpfa_pkg::ADDR_W-1:0] o_page_address,
    output logic [bpfa_pkg::ST_W-1:0]   o_status
);

    localparam int TOTAL_PAGES = MAP_BYTES * 8;
    localparam int WORDS       = (MAP_BYTES + 3) / 4;
    localparam int WADDR_W     = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int LAST_BITS   = TOTAL_PAGES - (WORDS - 1) * bpfa_pkg::WORD_W;
    localparam logic [WADDR_W-1:0] LAST_WORD = WADDR_W'(WORDS - 1);
    localparam logic [bpfa_pkg::WORD_W-1:0] TAIL_USED =
        ~({bpfa_pkg::WORD_W{1'b1}} >> (bpfa_pkg::WORD_W - LAST_BITS));

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_INIT,
        S_REL_WR,
        S_SCAN,
        S_FINISH
    } t_state;

    t_state                         r_state, n_state;
    logic [WADDR_W-1:0]             r_ptr, n_ptr;
    logic [WADDR_W-1:0]             r_hint, n_hint;
    logic [WADDR_W-1:0]             r_chk_addr, n_chk_addr;
    logic [WADDR_W-1:0]             r_rel_word, n_rel_word;
    logic [bpfa_pkg::BIT_W-1:0]     r_rel_bit, n_rel_bit;
    logic [bpfa_pkg::KB_W-1:0]      r_installed_kb, n_installed_kb;
    logic [bpfa_pkg::ADDR_W-1:0]    r_kernel_limit, n_kernel_limit;
    logic [bpfa_pkg::ADDR_W-1:0]    r_res_addr, n_res_addr;
    bpfa_pkg::t_status              r_res_status, n_res_status;
    logic                           r_out_valid, n_out_valid;
    logic [bpfa_pkg::ADDR_W-1:0]    r_out_addr, n_out_addr;
    bpfa_pkg::t_status              r_out_status, n_out_status;

    logic [bpfa_pkg::WORD_W-1:0]    r_map [WORDS];
    logic [bpfa_pkg::WORD_W-1:0]    r_rdata;

    logic                           mem_we;
    logic [WADDR_W-1:0]             mem_waddr;
    logic [bpfa_pkg::WORD_W-1:0]    mem_wdata;
    logic [WADDR_W-1:0]             mem_raddr;

    logic [bpfa_pkg::ADDR_W-1:0]    rel_page;
    logic [bpfa_pkg::CNT_W-1:0]     rsv_from;
    logic [bpfa_pkg::CNT_W-1:0]     krn_end;
    logic [bpfa_pkg::WORD_W-1:0]    fill_word;
    logic [bpfa_pkg::WORD_W-1:0]    scan_word;
    logic                           scan_found;
    logic [bpfa_pkg::BIT_W-1:0]     free_bit;
    logic [WADDR_W+bpfa_pkg::BIT_W-1:0] alloc_page;
    logic [bpfa_pkg::ADDR_W-1:0]    alloc_addr;

    assign rel_page = i_release_address >> PAGE_SHIFT;
    assign rsv_from = bpfa_pkg::CNT_W'(r_installed_kb >> (PAGE_SHIFT - 10))
                      & ~bpfa_pkg::CNT_W'(7);
    assign krn_end  = bpfa_pkg::CNT_W'(r_kernel_limit >> PAGE_SHIFT);

    bpfa_fill_word #(
        .WADDR_W (WADDR_W)
    ) u_fill (
        .i_word_idx (r_ptr),
        .i_rsv_from (rsv_from),
        .i_krn_end  (krn_end),
        .o_fill     (fill_word)
    );

    assign scan_word  = r_rdata | ((r_chk_addr == LAST_WORD) ? TAIL_USED : '0);
    assign scan_found = ~&scan_word;
    assign free_bit   = bpfa_pkg::lowest_zero(scan_word);
    assign alloc_page = {r_chk_addr, free_bit};
    assign alloc_addr = bpfa_pkg::ADDR_W'(alloc_page) << PAGE_SHIFT;

    always_comb begin
        n_state        = r_state;
        n_ptr          = r_ptr;
        n_hint         = r_hint;
        n_chk_addr     = r_chk_addr;
        n_rel_word     = r_rel_word;
        n_rel_bit      = r_rel_bit;
        n_installed_kb = r_installed_kb;
        n_kernel_limit = r_kernel_limit;
        n_res_addr     = r_res_addr;
        n_res_status   = r_res_status;
        n_out_valid    = r_out_valid;
        n_out_addr     = r_out_addr;
        n_out_status   = r_out_status;
        mem_we         = 1'b0;
        mem_waddr      = r_ptr;
        mem_wdata      = '0;
        mem_raddr      = r_chk_addr;

        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                bpfa_pkg::CFG_INSTALLED_KB: n_installed_kb = i_cfg_data[bpfa_pkg::KB_W-1:0];
                bpfa_pkg::CFG_KERNEL_LIMIT: n_kernel_limit = i_cfg_data;
            endcase
        end

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_CLEAR: begin
                mem_we = 1'b1;
                n_hint = '0;
                if (r_ptr == LAST_WORD) begin
                    n_ptr   = '0;
                    n_state = S_IDLE;
                end else begin
                    n_ptr = r_ptr + WADDR_W'(1);
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_res_addr   = '0;
                    n_res_status = bpfa_pkg::ST_OK;
                    unique case (bpfa_pkg::t_opcode'(i_opcode))
                        bpfa_pkg::OP_ALLOC: begin
                            mem_raddr  = r_hint;
                            n_chk_addr = r_hint;
                            n_state    = S_SCAN;
                        end
                        bpfa_pkg::OP_RELEASE: begin
                            if (rel_page >= bpfa_pkg::ADDR_W'(TOTAL_PAGES)) begin
                                n_res_status = bpfa_pkg::ST_RANGE;
                                n_state      = S_FINISH;
                            end else begin
                                mem_raddr  = rel_page[WADDR_W+bpfa_pkg::BIT_W-1:bpfa_pkg::BIT_W];
                                n_rel_word = rel_page[WADDR_W+bpfa_pkg::BIT_W-1:bpfa_pkg::BIT_W];
                                n_rel_bit  = rel_page[bpfa_pkg::BIT_W-1:0];
                                n_state    = S_REL_WR;
                            end
                        end
                        bpfa_pkg::OP_INIT: begin
                            n_ptr   = '0;
                            n_state = S_INIT;
                        end
                        bpfa_pkg::OP_NONE: begin
                            n_state = S_FINISH;
                        end
                    endcase
                end
            end
            S_INIT: begin
                mem_we    = 1'b1;
                mem_wdata = fill_word;
                if (r_ptr == LAST_WORD) begin
                    n_ptr   = '0;
                    n_hint  = '0;
                    n_state = S_FINISH;
                end else begin
                    n_ptr = r_ptr + WADDR_W'(1);
                end
            end
            S_REL_WR: begin
                mem_we    = 1'b1;
                mem_waddr = r_rel_word;
                mem_wdata = r_rdata & ~(bpfa_pkg::WORD_W'(1) << r_rel_bit);
                n_hint    = (r_rel_word < r_hint) ? r_rel_word : r_hint;
                n_state   = S_FINISH;
            end
            S_SCAN: begin
                if (scan_found) begin
                    mem_we     = 1'b1;
                    mem_waddr  = r_chk_addr;
                    mem_wdata  = r_rdata | (bpfa_pkg::WORD_W'(1) << free_bit);
                    n_hint     = r_chk_addr;
                    n_res_addr = alloc_addr;
                    n_state    = S_FINISH;
                end else if (r_chk_addr == LAST_WORD) begin
                    n_res_status = bpfa_pkg::ST_FULL;
                    n_state      = S_FINISH;
                end else begin
                    mem_raddr  = r_chk_addr + WADDR_W'(1);
                    n_chk_addr = r_chk_addr + WADDR_W'(1);
                end
            end
            S_FINISH: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid  = 1'b1;
                    n_out_addr   = r_res_addr;
                    n_out_status = r_res_status;
                    n_state      = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_CLEAR;
            r_ptr          <= '0;
            r_hint         <= '0;
            r_installed_kb <= '0;
            r_kernel_limit <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_ptr          <= n_ptr;
            r_hint         <= n_hint;
            r_installed_kb <= n_installed_kb;
            r_kernel_limit <= n_kernel_limit;
            r_out_valid    <= n_out_valid;
        end
        r_chk_addr   <= n_chk_addr;
        r_rel_word   <= n_rel_word;
        r_rel_bit    <= n_rel_bit;
        r_res_addr   <= n_res_addr;
        r_res_status <= n_res_status;
        r_out_addr   <= n_out_addr;
        r_out_status <= n_out_status;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_map[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_map[mem_raddr];
    end

    assign o_cfg_ready    = 1'b1;
    assign o_in_stall     = (r_state != S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_page_address = r_out_addr;
    assign o_status       = r_out_status;

    `AM_ASSERT_IMPL(a_full_has_no_addr, i_clk, i_rst_n, r_out_valid && r_out_status == bpfa_pkg::ST_FULL, r_out_addr == '0)
    `AM_ASSERT_NEXT(a_accept_locks_input, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)
    `AM_ASSERT_IMPL(a_write_only_busy, i_clk, i_rst_n, mem_we, r_state != S_IDLE && r_state != S_FINISH)

endmodule

[rtl/bpfa_fill_word.sv]
// Computes one map word written by the initialize sweep: reserved tail pages
// and kernel pages. Depends on bpfa_pkg.
module bpfa_fill_word #(
    parameter int WADDR_W = 10
) (
    input  logic [WADDR_W-1:0]          i_word_idx,
    input  logic [bpfa_pkg::CNT_W-1:0]  i_rsv_from,
    input  logic [bpfa_pkg::CNT_W-1:0]  i_krn_end,
    output logic [bpfa_pkg::WORD_W-1:0] o_fill
);

    logic [bpfa_pkg::CNT_W-1:0]  base;
    logic [bpfa_pkg::CNT_W-1:0]  base_end;
    logic [bpfa_pkg::CNT_W-1:0]  rsv_off;
    logic [bpfa_pkg::CNT_W-1:0]  krn_off;
    logic [bpfa_pkg::WORD_W-1:0] hi_mask;
    logic [bpfa_pkg::WORD_W-1:0] lo_mask;

    assign base     = bpfa_pkg::CNT_W'({i_word_idx, {bpfa_pkg::BIT_W{1'b0}}});
    assign base_end = base + bpfa_pkg::CNT_W'(bpfa_pkg::WORD_W);
    assign rsv_off  = i_rsv_from - base;
    assign krn_off  = i_krn_end - base;

    always_comb begin
        if (i_rsv_from <= base) begin
            hi_mask = '1;
        end else if (i_rsv_from >= base_end) begin
            hi_mask = '0;
        end else begin
            hi_mask = {bpfa_pkg::WORD_W{1'b1}} << rsv_off[bpfa_pkg::BIT_W-1:0];
        end
        if (i_krn_end >= base_end) begin
            lo_mask = '1;
        end else if (i_krn_end <= base) begin
            lo_mask = '0;
        end else begin
            lo_mask = (bpfa_pkg::WORD_W'(1) << krn_off[bpfa_pkg::BIT_W-1:0])
                      - bpfa_pkg::WORD_W'(1);
        end
    end

    assign o_fill = hi_mask | lo_mask;

endmodule
